// ----- src/oelev_pkg.sv -----
// Package for the oldest-entry limit evictor.
// Holds the entry word type, the sequencer states and the field and register codes.
// No dependencies.
package oelev_pkg;

	localparam int unsigned ID_W    = 32;
	localparam int unsigned STAMP_W = 32;
	localparam int unsigned LIMIT_W = 8;
	localparam int unsigned COUNT_W = 8;

	localparam logic [LIMIT_W-1:0] LIMIT_RESET = 8'd64;

	localparam logic CFG_IDX_LIMIT  = 1'b0;
	localparam logic CFG_IDX_EVICT  = 1'b1;

	localparam logic ACT_REGISTER   = 1'b0;
	localparam logic ACT_UNREGISTER = 1'b1;

	localparam logic STATUS_DONE    = 1'b0;
	localparam logic STATUS_FULL    = 1'b1;

	typedef struct packed {
		logic               valid;
		logic [ID_W-1:0]    key;
		logic [STAMP_W-1:0] stamp;
	} entry_t;

	typedef enum logic [2:0] {
		ST_CLEAR,
		ST_IDLE,
		ST_SCAN,
		ST_UPDATE,
		ST_EVICT
	} state_t;

endpackage

// ----- src/oldest_entry_limit_evictor.sv -----
// Oldest-entry limit evictor: id table in one synchronous memory with a scan sequencer.
// Depends on oelev_pkg for the entry type, the states and the codes.
// Each item scans the whole table with one memory read per entry, then writes the update, and
// the eviction when an entry is evicted, before done rises; the next start beat is taken in the
// done cycle, so one item is handled at a time.
// After reset the block clears the memory with busy high.
module oldest_entry_limit_evictor
	import oelev_pkg::*;
#(
	parameter int unsigned TABLE_ENTRIES = 128
) (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                start,
	output logic                busy,
	input  logic                action,
	input  logic [ID_W-1:0]     item_id,
	input  logic [STAMP_W-1:0]  time_now,
	input  logic                cfg_valid,
	output logic                cfg_ready,
	input  logic                cfg_index,
	input  logic [LIMIT_W-1:0]  cfg_data,
	output logic                done,
	output logic                evicted,
	output logic [ID_W-1:0]     evicted_id,
	output logic                status,
	output logic [COUNT_W-1:0]  entry_count
);

	localparam int unsigned AW = $clog2(TABLE_ENTRIES);
	localparam int unsigned CW = $clog2(TABLE_ENTRIES + 1);
	localparam int unsigned XW = (CW > COUNT_W) ? CW : COUNT_W;
	localparam logic [CW-1:0] DEPTH = CW'(TABLE_ENTRIES);
	localparam logic [CW-1:0] LAST  = CW'(TABLE_ENTRIES - 1);

	entry_t mem [TABLE_ENTRIES];

	state_t state_q, state_d;

	logic [LIMIT_W-1:0] limit_q;
	logic               evict_en_q;
	logic [CW-1:0]      held_count_q;
	logic [CW-1:0]      cnt_q;

	logic               action_q;
	logic [ID_W-1:0]    id_q;
	logic [STAMP_W-1:0] now_q;

	logic               rd_vld_s1;
	logic [AW-1:0]      rd_addr_s1;
	entry_t             rd_data_s1;

	logic               found_q;
	logic [AW-1:0]      match_q;
	logic               free_found_q;
	logic [AW-1:0]      free_q;
	logic               best_found_q;
	logic [AW-1:0]      best_slot_q;
	logic [ID_W-1:0]    best_key_q;
	logic [STAMP_W-1:0] best_stamp_q;

	logic               done_q;
	logic               evicted_q;
	logic [ID_W-1:0]    evicted_id_q;
	logic               status_q;
	logic [COUNT_W-1:0] entry_count_q;

	logic               mem_we;
	logic [AW-1:0]      mem_waddr;
	entry_t             mem_wdata;
	logic               rd_issue;
	logic               scan_last;
	logic               is_reg;
	logic               is_full;
	logic [CW-1:0]      count_next;
	logic               evict_go;
	logic               older;

	assign rd_issue  = (state_q == ST_SCAN) && (cnt_q < DEPTH);
	assign scan_last = rd_vld_s1 && (rd_addr_s1 == LAST[AW-1:0]);
	assign is_reg    = (action_q == ACT_REGISTER);
	assign is_full   = is_reg && !found_q && !free_found_q;

	always_comb begin
		count_next = held_count_q;
		if (is_reg && !found_q && free_found_q) begin
			count_next = held_count_q + CW'(1);
		end else if (!is_reg && found_q) begin
			count_next = held_count_q - CW'(1);
		end
	end

	assign evict_go = is_reg && !is_full && evict_en_q && (limit_q != '0) &&
		(XW'(count_next) > XW'(limit_q)) && best_found_q;

	assign older = (rd_data_s1.stamp < best_stamp_q) ||
		(best_found_q && (rd_data_s1.stamp == best_stamp_q) &&
		(rd_data_s1.key < best_key_q));

	always_comb begin
		state_d = state_q;
		case (state_q)
			ST_CLEAR: begin
				if (cnt_q == LAST) begin
					state_d = ST_IDLE;
				end
			end
			ST_IDLE: begin
				if (start) begin
					state_d = ST_SCAN;
				end
			end
			ST_SCAN: begin
				if (scan_last) begin
					state_d = ST_UPDATE;
				end
			end
			ST_UPDATE: begin
				state_d = evict_go ? ST_EVICT : ST_IDLE;
			end
			ST_EVICT: begin
				state_d = ST_IDLE;
			end
			default: begin
				state_d = ST_CLEAR;
			end
		endcase
	end

	always_comb begin
		busy      = 1'b1;
		mem_we    = 1'b0;
		mem_waddr = cnt_q[AW-1:0];
		mem_wdata = '0;
		case (state_q)
			ST_CLEAR: begin
				mem_we = 1'b1;
			end
			ST_IDLE: begin
				busy = 1'b0;
			end
			ST_UPDATE: begin
				if (!is_reg) begin
					mem_we    = found_q;
					mem_waddr = match_q;
				end else begin
					mem_we    = found_q || free_found_q;
					mem_waddr = found_q ? match_q : free_q;
					mem_wdata = '{valid: 1'b1, key: id_q, stamp: now_q};
				end
			end
			ST_EVICT: begin
				mem_we    = 1'b1;
				mem_waddr = best_slot_q;
			end
			default: begin
				busy = 1'b1;
			end
		endcase
	end

	always_ff @(posedge clk) begin
		if (mem_we) begin
			mem[mem_waddr] <= mem_wdata;
		end
		rd_data_s1 <= mem[cnt_q[AW-1:0]];
		rd_addr_s1 <= cnt_q[AW-1:0];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q      <= ST_CLEAR;
			cnt_q        <= '0;
			rd_vld_s1    <= 1'b0;
			limit_q      <= LIMIT_RESET;
			evict_en_q   <= 1'b0;
			held_count_q <= '0;
			done_q       <= 1'b0;
		end else begin
			state_q   <= state_d;
			rd_vld_s1 <= rd_issue;
			done_q    <= (state_q == ST_EVICT) || ((state_q == ST_UPDATE) && !evict_go);
			if (cfg_valid) begin
				if (cfg_index == CFG_IDX_LIMIT) begin
					limit_q <= cfg_data;
				end else begin
					evict_en_q <= cfg_data[0];
				end
			end
			if (state_q == ST_CLEAR || rd_issue) begin
				cnt_q <= cnt_q + CW'(1);
			end else if (state_q == ST_IDLE) begin
				cnt_q <= '0;
			end
			if (state_q == ST_UPDATE) begin
				held_count_q <= count_next;
			end else if (state_q == ST_EVICT) begin
				held_count_q <= held_count_q - CW'(1);
			end
		end
	end

	always_ff @(posedge clk) begin
		if (state_q == ST_IDLE && start) begin
			action_q     <= action;
			id_q         <= item_id;
			now_q        <= time_now;
			found_q      <= 1'b0;
			free_found_q <= 1'b0;
			best_found_q <= 1'b0;
			best_stamp_q <= time_now;
		end else if (rd_vld_s1) begin
			if (rd_data_s1.valid && (rd_data_s1.key == id_q) && !found_q) begin
				found_q <= 1'b1;
				match_q <= rd_addr_s1;
			end
			if (!rd_data_s1.valid && !free_found_q) begin
				free_found_q <= 1'b1;
				free_q       <= rd_addr_s1;
			end
			if (rd_data_s1.valid && (rd_data_s1.key != id_q) && older) begin
				best_found_q <= 1'b1;
				best_slot_q  <= rd_addr_s1;
				best_key_q   <= rd_data_s1.key;
				best_stamp_q <= rd_data_s1.stamp;
			end
		end
	end

	logic [XW-1:0] count_x;
	assign count_x = (state_q == ST_EVICT) ? XW'(held_count_q - CW'(1)) : XW'(count_next);

	always_ff @(posedge clk) begin
		if (state_q == ST_UPDATE || state_q == ST_EVICT) begin
			evicted_q     <= (state_q == ST_EVICT);
			evicted_id_q  <= (state_q == ST_EVICT) ? best_key_q : '0;
			status_q      <= is_full ? STATUS_FULL : STATUS_DONE;
			entry_count_q <= (count_x > XW'(255)) ? {COUNT_W{1'b1}} : count_x[COUNT_W-1:0];
		end
	end

	assign cfg_ready   = 1'b1;
	assign done        = done_q;
	assign evicted     = evicted_q;
	assign evicted_id  = evicted_id_q;
	assign status      = status_q;
	assign entry_count = entry_count_q;

	a_done_source: assert property (@(posedge clk) disable iff (!arst_n)
		done_q |-> ($past(state_q) == ST_UPDATE || $past(state_q) == ST_EVICT))
		else $error("done without a finished item");

	a_evict_not_full: assert property (@(posedge clk) disable iff (!arst_n)
		(done_q && evicted_q) |-> (status_q == STATUS_DONE))
		else $error("eviction reported on a dropped register");

	a_count_bound: assert property (@(posedge clk) disable iff (!arst_n)
		held_count_q <= DEPTH)
		else $error("entry count above table size");

	a_no_write_in_scan: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_SCAN) |-> !mem_we)
		else $error("table written during scan");

endmodule

// ----- verif/tb_top.sv -----
// Self-checking testbench for oldest_entry_limit_evictor: directed and random register and
// unregister commands, with a table predictor that checks every result beat in order.
// Depends on oelev_pkg and the oldest_entry_limit_evictor RTL.
module tb_top;
	import oelev_pkg::*;

	localparam int TABLE_ENTRIES = 128;
	localparam int WATCHDOG_LIMIT = 5000;

	typedef struct packed {
		logic               action;
		logic [ID_W-1:0]    id;
		logic [STAMP_W-1:0] now;
	} command_t;

	typedef struct packed {
		logic               evicted;
		logic [ID_W-1:0]    evicted_id;
		logic               status;
		logic [COUNT_W-1:0] entries;
	} outcome_t;

	logic               clk = 1'b0;
	logic               arst_n = 1'b0;
	logic               start = 1'b0;
	logic               busy;
	logic               action = ACT_REGISTER;
	logic [ID_W-1:0]    item_id = '0;
	logic [STAMP_W-1:0] time_now = '0;
	logic               cfg_valid = 1'b0;
	logic               cfg_ready;
	logic               cfg_index = CFG_IDX_LIMIT;
	logic [LIMIT_W-1:0] cfg_data = '0;
	logic               done;
	logic               evicted;
	logic [ID_W-1:0]    evicted_id;
	logic               status;
	logic [COUNT_W-1:0] entry_count;

	command_t cmd_q[$];
	outcome_t outcome_q[$];
	int       mismatches = 0;
	int       hold_off = 0;
	int       quiet_cycles = 0;
	bit       steady_drive = 1'b0;

	bit                 tbl_valid [TABLE_ENTRIES];
	logic [ID_W-1:0]    tbl_key [TABLE_ENTRIES];
	logic [STAMP_W-1:0] tbl_stamp [TABLE_ENTRIES];
	int                 held_entries = 0;
	logic [LIMIT_W-1:0] entry_limit = LIMIT_RESET;
	logic               evict_on = 1'b0;

	logic [ID_W-1:0]    id_pool [256];
	logic [STAMP_W-1:0] clock_ticks;

	oldest_entry_limit_evictor #(
		.TABLE_ENTRIES(TABLE_ENTRIES)
	) DUT (
		.clk(clk),
		.arst_n(arst_n),
		.start(start),
		.busy(busy),
		.action(action),
		.item_id(item_id),
		.time_now(time_now),
		.cfg_valid(cfg_valid),
		.cfg_ready(cfg_ready),
		.cfg_index(cfg_index),
		.cfg_data(cfg_data),
		.done(done),
		.evicted(evicted),
		.evicted_id(evicted_id),
		.status(status),
		.entry_count(entry_count)
	);

	always #5 clk = ~clk;

	function automatic outcome_t table_update(input command_t cmd);
		outcome_t res;
		int slot;
		int spare;
		int best;
		logic [STAMP_W-1:0] best_stamp;
		res = '0;
		slot = -1;
		spare = -1;
		for (int i = 0; i < TABLE_ENTRIES; i++) begin
			if (tbl_valid[i] && tbl_key[i] == cmd.id && slot < 0)
				slot = i;
			if (!tbl_valid[i] && spare < 0)
				spare = i;
		end
		if (cmd.action == ACT_UNREGISTER) begin
			if (slot >= 0) begin
				tbl_valid[slot] = 1'b0;
				held_entries--;
			end
		end else if (slot < 0 && spare < 0) begin
			res.status = STATUS_FULL;
		end else begin
			if (slot < 0) begin
				slot = spare;
				tbl_valid[slot] = 1'b1;
				tbl_key[slot] = cmd.id;
				held_entries++;
			end
			tbl_stamp[slot] = cmd.now;
			if (evict_on && entry_limit != 0 && held_entries > int'(entry_limit)) begin
				best = -1;
				best_stamp = cmd.now;
				for (int i = 0; i < TABLE_ENTRIES; i++) begin
					if (tbl_valid[i] && (tbl_stamp[i] < best_stamp ||
					    (best >= 0 && tbl_stamp[i] == best_stamp &&
					     tbl_key[i] < tbl_key[best]))) begin
						best = i;
						best_stamp = tbl_stamp[i];
					end
				end
				if (best >= 0) begin
					res.evicted = 1'b1;
					res.evicted_id = tbl_key[best];
					tbl_valid[best] = 1'b0;
					held_entries--;
				end
			end
		end
		res.entries = held_entries > 255 ? 8'd255 : COUNT_W'(held_entries);
		return res;
	endfunction

	always @(posedge clk) begin
		command_t taken;
		command_t next_cmd;
		if (!arst_n) begin
			start <= 1'b0;
		end else begin
			if (start && !busy) begin
				taken.action = action;
				taken.id = item_id;
				taken.now = time_now;
				outcome_q = {outcome_q, table_update(taken)};
			end
			if (!start || !busy) begin
				if (start && !steady_drive && $urandom_range(0, 99) < 13) begin
					start <= 1'b0;
					hold_off <= $urandom_range(1, 150);
				end else if (hold_off != 0) begin
					start <= 1'b0;
					hold_off <= hold_off - 1;
				end else if (cmd_q.size() == 0 ||
				             (!steady_drive && $urandom_range(0, 99) < 13)) begin
					start <= 1'b0;
				end else begin
					next_cmd = cmd_q.pop_front();
					start <= 1'b1;
					action <= next_cmd.action;
					item_id <= next_cmd.id;
					time_now <= next_cmd.now;
				end
			end
		end
	end

	task automatic check_field(input string what, input logic [31:0] want,
	                           input logic [31:0] got);
		if (got !== want) begin
			$display("%0t: %s mismatch, expected %0h, actual %0h", $time, what, want, got);
			mismatches++;
		end
	endtask

	always @(posedge clk) begin
		outcome_t want;
		if (arst_n && done) begin
			if (outcome_q.size() == 0) begin
				$display("%0t: result beat with none expected, actual id %0h count %0d",
				         $time, evicted_id, entry_count);
				mismatches++;
			end else begin
				want = outcome_q.pop_front();
				check_field("evicted", 32'(want.evicted), 32'(evicted));
				check_field("evicted_id", want.evicted_id, evicted_id);
				check_field("status", 32'(want.status), 32'(status));
				check_field("entry_count", 32'(want.entries), 32'(entry_count));
			end
		end
	end

	always @(posedge clk) begin
		if ((start && !busy) || done || (cfg_valid && cfg_ready))
			quiet_cycles <= 0;
		else
			quiet_cycles <= quiet_cycles + 1;
		if (quiet_cycles >= WATCHDOG_LIMIT) begin
			$display("DONE: errors detected");
			$finish;
		end
	end

	task automatic write_reg(input logic idx, input logic [LIMIT_W-1:0] data);
		@(posedge clk);
		cfg_valid <= 1'b1;
		cfg_index <= idx;
		cfg_data <= data;
		do @(posedge clk); while (!cfg_ready);
		cfg_valid <= 1'b0;
		if (idx == CFG_IDX_LIMIT)
			entry_limit = data;
		else
			evict_on = data[0];
	endtask

	task automatic queue_item(input logic act, input logic [ID_W-1:0] id,
	                          input logic [STAMP_W-1:0] now);
		command_t cmd;
		cmd.action = act;
		cmd.id = id;
		cmd.now = now;
		cmd_q = {cmd_q, cmd};
	endtask

	task automatic drain();
		do @(posedge clk); while (cmd_q.size() != 0 || start || outcome_q.size() != 0);
		repeat (4) @(posedge clk);
	endtask

	task automatic run_phase(input logic [LIMIT_W-1:0] limit, input logic enable,
	                         input int count, input int span, input int reg_pct,
	                         input bit steady);
		logic               act;
		logic [ID_W-1:0]    id;
		logic [STAMP_W-1:0] now;
		int                 roll;
		write_reg(CFG_IDX_LIMIT, limit);
		write_reg(CFG_IDX_EVICT, LIMIT_W'(enable));
		steady_drive = steady;
		for (int n = 0; n < count; n++) begin
			act = ($urandom_range(0, 99) < reg_pct) ? ACT_REGISTER : ACT_UNREGISTER;
			id = ($urandom_range(0, 99) < 88) ? id_pool[$urandom_range(0, span)] : $urandom();
			roll = $urandom_range(0, 99);
			if (roll < 90) begin
				clock_ticks = clock_ticks + $urandom_range(0, 3);
				now = clock_ticks;
			end else if (roll < 96) begin
				now = $urandom();
			end else begin
				now = $urandom_range(0, 1) ? '1 : '0;
			end
			queue_item(act, id, now);
		end
		drain();
		steady_drive = 1'b0;
	endtask

	initial begin
		id_pool[0] = '0;
		id_pool[1] = '1;
		for (int i = 2; i < 256; i++)
			id_pool[i] = $urandom();
		clock_ticks = $urandom_range(16, 1000);

		repeat (6) @(posedge clk);
		arst_n <= 1'b1;

		queue_item(ACT_REGISTER, 32'h0000_0000, 32'h0000_0000);
		queue_item(ACT_REGISTER, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
		queue_item(ACT_REGISTER, 32'h0000_0000, 32'h0000_0005);
		queue_item(ACT_UNREGISTER, 32'h0001_2345, 32'h0000_0006);
		queue_item(ACT_UNREGISTER, 32'hFFFF_FFFF, 32'h0000_0007);
		queue_item(ACT_REGISTER, 32'hA5A5_A5A5, 32'h0000_000A);
		queue_item(ACT_REGISTER, 32'h5A5A_5A5A, 32'h0000_000A);
		queue_item(ACT_UNREGISTER, 32'h0000_0000, 32'h0000_000B);
		queue_item(ACT_UNREGISTER, 32'hA5A5_A5A5, 32'h0000_000C);
		queue_item(ACT_UNREGISTER, 32'h5A5A_5A5A, 32'h0000_000D);
		drain();

		write_reg(CFG_IDX_LIMIT, 8'd2);
		write_reg(CFG_IDX_EVICT, 8'd1);
		queue_item(ACT_REGISTER, 32'h0000_0300, 32'd100);
		queue_item(ACT_REGISTER, 32'h0000_0200, 32'd100);
		queue_item(ACT_REGISTER, 32'h0000_0100, 32'd100);
		queue_item(ACT_REGISTER, 32'h0000_0400, 32'd200);
		queue_item(ACT_REGISTER, 32'h0000_0200, 32'd300);
		queue_item(ACT_REGISTER, 32'h0000_0500, 32'd0);
		queue_item(ACT_REGISTER, 32'h0000_0600, 32'hFFFF_FFFF);
		queue_item(ACT_UNREGISTER, 32'h0000_0400, 32'd301);
		queue_item(ACT_UNREGISTER, 32'h0000_0200, 32'd302);
		queue_item(ACT_UNREGISTER, 32'h0000_0600, 32'd303);
		drain();

		run_phase(8'd1, 1'b1, 120, 40, 70, 1'b0);
		run_phase(8'd0, 1'b1, 130, 200, 85, 1'b0);
		run_phase(8'd64, 1'b0, 140, 255, 90, 1'b1);
		run_phase(8'd128, 1'b1, 90, 255, 80, 1'b0);
		run_phase(8'd200, 1'b1, 70, 255, 30, 1'b0);
		run_phase(8'd100, 1'b1, 130, 255, 75, 1'b0);
		run_phase(8'd5, 1'b1, 120, 30, 60, 1'b0);
		run_phase(8'd255, 1'b1, 80, 255, 20, 1'b0);

		repeat (TABLE_ENTRIES + 8) @(posedge clk);
		if (mismatches == 0)
			$display("DONE: 0 errors");
		else
			$display("DONE: errors detected");
		$finish;
	end

endmodule
